// ===== sv/hjb_pkg.sv =====
// Shared definitions for the chained hash-join unit: sizes, action codes,
// controller states, command and status structs, count clipping.
// No dependencies.
`default_nettype none

package hjb_pkg;

  // Table geometry (BUCKETS is a power of two)
  localparam int BUCKETS = 1024;
  localparam int NODES   = 1024;

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
  // A head or link holds node index + 1, zero is the empty pointer
  localparam int PTR_W  = $clog2(NODES + 1);

  localparam int KEY_W = 32;
  localparam int SUM_W = 32;
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E3779B1;

  // Action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_PROBE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_INS,
    S_PTR,
    S_WALK,
    S_NODE,
    S_SUM,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic ld_item;   // capture action and key, zero status and count
    logic mul;       // hash multiply
    logic rej;       // flag pool-full rejection
    logic head_rd;   // read bucket head, latch bucket index
    logic ins_wr;    // link new node at chain head
    logic clr_init;  // restart clear sweep, zero fill and total
    logic clr_wr;    // clear one bucket head
    logic ptr_ld;    // load walk pointer from head
    logic node_rd;   // read node key and link
    logic node_acc;  // compare key, follow link
    logic sum_upd;   // saturating add into total
    logic out_ld;    // load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       walk_end;
    logic       clr_last;
    logic       out_free;
  } stat_t;

  // Saturate a pointer-width count to the result field width
  function automatic logic [CNT_W-1:0] clip_cnt(input logic [PTR_W-1:0] v);
    logic [PTR_W+CNT_W-1:0] ext;
    logic [PTR_W+CNT_W-1:0] lim;
    begin
      ext = {{CNT_W{1'b0}}, v};
      lim = {{PTR_W{1'b0}}, CNT_MAX};
      if (ext > lim) return CNT_MAX;
      return ext[CNT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/hjb_if.sv =====
// Valid/ready channel interfaces for items and results.
// Depends on hjb_pkg for field widths.
`default_nettype none

interface hjb_in_if;
  import hjb_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [KEY_W-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface hjb_out_if;
  import hjb_pkg::*;
  logic             valid;
  logic             ready;
  logic             status;
  logic [CNT_W-1:0] match_count;
  logic [SUM_W-1:0] total_matches;
  logic [CNT_W-1:0] stored_nodes;

  modport source (output valid, output status, output match_count,
                  output total_matches, output stored_nodes, input ready);
  modport sink   (input valid, input status, input match_count,
                  input total_matches, input stored_nodes, output ready);
endinterface

`default_nettype wire

// ===== sv/hash_join_build_probe_unit.sv =====
// Top level of the chained hash-join unit: controller plus datapath.
// Depends on hjb_pkg, hjb_if, hjb_ctrl, hjb_dp.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    action[1:0], key[31:0]
//   out_ch   out  valid/ready    status, match_count[10:0],
//                                total_matches[31:0], stored_nodes[10:0]
//
// Insert: capture, multiply, head read, link, result load.
// Probe: each node of the chain costs one registered read of the node
// memories and one compare/follow step.
// Clear: one bucket head zeroed per cycle, across all BUCKETS heads.
// After reset the same sweep runs over every bucket head before in_ch.ready rises.
// The result register lets the next item enter while a result waits;
// a new result is held back until out_ch takes the previous one.
`default_nettype none

module hash_join_build_probe_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  hjb_in_if.sink    in_ch,
  hjb_out_if.source out_ch
);
  import hjb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  hjb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hjb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_action         (in_ch.action),
    .in_key            (in_ch.key),
    .cmd               (cmd),
    .stat              (stat),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_match_count   (out_ch.match_count),
    .out_total_matches (out_ch.total_matches),
    .out_stored_nodes  (out_ch.stored_nodes)
  );

endmodule

`default_nettype wire

// ===== sv/hjb_ctrl.sv =====
// Sequencer for the hash-join unit: clear sweep, insert, probe walk,
// result hand-off. Depends on hjb_pkg.
`default_nettype none

module hjb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [1:0]     in_action,
  output logic                in_ready,
  input  wire hjb_pkg::stat_t stat,
  output hjb_pkg::cmd_t       cmd
);
  import hjb_pkg::*;

  state_t state_r, state_nxt;
  logic   clr_resp_r, clr_resp_nxt;  // sweep was started by a clear item
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_resp_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_resp_r <= clr_resp_nxt;
    end
  end

  // Next state; the incoming action is decoded before it is captured
  always_comb begin
    state_nxt    = state_r;
    clr_resp_nxt = clr_resp_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = clr_resp_r ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_INSERT, ACT_PROBE: state_nxt = S_HASH;
            ACT_CLEAR: begin
              state_nxt    = S_CLEAR;
              clr_resp_nxt = 1'b1;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_HASH: begin
        if (stat.action == ACT_INSERT && stat.full) state_nxt = S_DONE;
        else                                        state_nxt = S_HEAD;
      end
      S_HEAD:  state_nxt = (stat.action == ACT_INSERT) ? S_INS : S_PTR;
      S_INS:   state_nxt = S_DONE;
      S_PTR:   state_nxt = S_WALK;
      S_WALK:  state_nxt = stat.walk_end ? S_SUM : S_NODE;
      S_NODE:  state_nxt = S_WALK;
      S_SUM:   state_nxt = S_DONE;
      S_DONE:  if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        cmd.ld_item  = accept;
        cmd.clr_init = accept && (in_action == ACT_CLEAR);
      end
      S_HASH: begin
        cmd.mul = 1'b1;
        cmd.rej = (stat.action == ACT_INSERT) && stat.full;
      end
      S_HEAD:  cmd.head_rd  = 1'b1;
      S_INS:   cmd.ins_wr   = 1'b1;
      S_PTR:   cmd.ptr_ld   = 1'b1;
      S_WALK:  cmd.node_rd  = !stat.walk_end;
      S_NODE:  cmd.node_acc = 1'b1;
      S_SUM:   cmd.sum_upd  = 1'b1;
      S_DONE:  cmd.out_ld   = stat.out_free;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTH
  // Only one memory write source at a time
  a_one_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_wr && cmd.ins_wr))
    else $error("clear sweep and insert write together");
  // A clear item restarts the sweep on the next cycle
  a_clr_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_init |=> (state_r == S_CLEAR && clr_resp_r))
    else $error("clear item did not start sweep");
  // A node read is always followed by its accumulate
  a_node_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.node_rd |=> cmd.node_acc)
    else $error("node read without accumulate");
`endif

endmodule

`default_nettype wire

// ===== sv/hjb_dp.sv =====
// Datapath for the hash-join unit: hash multiplier, bucket head, node key
// and node link memories, walk registers, totals, result register.
// Depends on hjb_pkg.
`default_nettype none

module hjb_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [1:0]                in_action,
  input  wire logic [hjb_pkg::KEY_W-1:0] in_key,
  input  wire hjb_pkg::cmd_t             cmd,
  output hjb_pkg::stat_t                 stat,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic                           out_status,
  output logic [hjb_pkg::CNT_W-1:0]      out_match_count,
  output logic [hjb_pkg::SUM_W-1:0]      out_total_matches,
  output logic [hjb_pkg::CNT_W-1:0]      out_stored_nodes
);
  import hjb_pkg::*;

  // Memories
  logic [PTR_W-1:0] head_mem [BUCKETS];
  logic [KEY_W-1:0] key_mem  [NODES];
  logic [PTR_W-1:0] link_mem [NODES];

  // Item and walk registers (payload, no reset)
  logic [1:0]       act_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] prod_r;
  logic [BKT_W-1:0] bkt_r;
  logic [PTR_W-1:0] head_q;
  logic [KEY_W-1:0] nkey_q;
  logic [PTR_W-1:0] nlink_q;
  logic [PTR_W-1:0] ptr_r;
  logic [PTR_W-1:0] steps_r;
  logic [PTR_W-1:0] cnt_r;
  logic             status_r;

  // Control state
  logic [BKT_W-1:0] clr_idx_r;
  logic [PTR_W-1:0] fill_r;
  logic [SUM_W-1:0] sum_r;
  logic             out_valid_r;

  logic [CNT_W-1:0] res_cnt_r;
  logic [SUM_W-1:0] res_sum_r;
  logic [CNT_W-1:0] res_fill_r;
  logic             res_status_r;

  logic [KEY_W-1:0] hash_c;
  logic [BKT_W-1:0] bkt_c;
  logic [PTR_W-1:0] ptr_m1;
  logic [NODE_W-1:0] node_idx;
  logic [NODE_W-1:0] fill_idx;
  logic [PTR_W-1:0] fill_p1;
  logic [SUM_W:0]   sum_ext;
  logic             full;

  // Hash finish and bucket select
  assign hash_c   = prod_r ^ (prod_r >> 16);
  assign bkt_c    = hash_c[BKT_W-1:0];
  assign ptr_m1   = ptr_r - 1'b1;
  assign node_idx = ptr_m1[NODE_W-1:0];
  assign fill_idx = fill_r[NODE_W-1:0];
  assign fill_p1  = fill_r + 1'b1;
  assign full     = (fill_r == PTR_W'(NODES));
  assign sum_ext  = {1'b0, sum_r} + {{(SUM_W + 1 - PTR_W){1'b0}}, cnt_r};

  // Status to controller
  assign stat.action   = act_r;
  assign stat.full     = full;
  assign stat.walk_end = (ptr_r == '0) || (ptr_r > fill_r) || (steps_r >= fill_r);
  assign stat.clr_last = (clr_idx_r == BKT_W'(BUCKETS - 1));
  assign stat.out_free = !out_valid_r || out_ready;

  // Item capture, hash multiply, walk
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      act_r    <= in_action;
      key_r    <= in_key;
      status_r <= 1'b0;
      cnt_r    <= '0;
    end
    if (cmd.mul)     prod_r   <= key_r * HASH_MULT;
    if (cmd.rej)     status_r <= 1'b1;
    if (cmd.head_rd) bkt_r    <= bkt_c;
    if (cmd.ptr_ld) begin
      ptr_r   <= head_q;
      steps_r <= '0;
    end
    if (cmd.node_acc) begin
      if (nkey_q == key_r) cnt_r <= cnt_r + 1'b1;
      ptr_r   <= nlink_q;
      steps_r <= steps_r + 1'b1;
    end
  end

  // Bucket head memory: one write port, one registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_wr)      head_mem[clr_idx_r] <= '0;
    else if (cmd.ins_wr) head_mem[bkt_r]     <= fill_p1;
    if (cmd.head_rd)     head_q              <= head_mem[bkt_c];
  end

  // Node memories
  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      key_mem[fill_idx]  <= key_r;
      link_mem[fill_idx] <= head_q;
    end
    if (cmd.node_rd) begin
      nkey_q  <= key_mem[node_idx];
      nlink_q <= link_mem[node_idx];
    end
  end

  // Sweep index, fill count, running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
    end else begin
      if (cmd.clr_init) begin
        clr_idx_r <= '0;
        fill_r    <= '0;
        sum_r     <= '0;
      end else begin
        if (cmd.clr_wr) clr_idx_r <= clr_idx_r + 1'b1;
        if (cmd.ins_wr) fill_r    <= fill_p1;
        if (cmd.sum_upd) sum_r    <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      res_status_r <= status_r;
      res_cnt_r    <= (act_r == ACT_PROBE) ? clip_cnt(cnt_r) : '0;
      res_sum_r    <= sum_r;
      res_fill_r   <= clip_cnt(fill_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_status_r;
  assign out_match_count   = res_cnt_r;
  assign out_total_matches = res_sum_r;
  assign out_stored_nodes  = res_fill_r;

`ifndef SYNTH
  // Pool never overfills
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= PTR_W'(NODES))
    else $error("fill count beyond pool size");
  // An insert write grows the pool by exactly one
  a_fill_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |=> fill_r == $past(fill_p1))
    else $error("fill count did not advance on insert");
  // Total only drops on a clear
  a_sum_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clr_init |=> sum_r >= $past(sum_r))
    else $error("running total decreased");
  // A result is never overwritten while still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_hash_join_build_probe_unit.sv =====
// Self-checking testbench for hash_join_build_probe_unit: drives insert, probe, clear
// and unused-action transactions and checks every result against a built-in table model.
// Depends on hjb_pkg, hjb_if and the unit itself.
`default_nettype none

module tb_hash_join_build_probe_unit;
  import hjb_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int STALL_CYCLES = 400;
  localparam int MIX_ITEMS    = 600;
  localparam int TAIL_ITEMS   = 150;
  localparam int KEY_POOL     = 12;

  typedef struct packed {
    logic             status;
    logic [CNT_W-1:0] match_count;
    logic [SUM_W-1:0] total_matches;
    logic [CNT_W-1:0] stored_nodes;
  } join_result_t;

  // Table model plus the queue of results still owed by the unit
  class join_scoreboard;
    logic [PTR_W-1:0] bucket_head [BUCKETS];
    logic [KEY_W-1:0] node_key [NODES];
    logic [PTR_W-1:0] node_link [NODES];
    int unsigned      node_fill;
    logic [SUM_W-1:0] match_total;
    join_result_t     pending_results [$];
    int unsigned      failures;

    function new();
      failures = 0;
      empty_table();
    endfunction

    function void empty_table();
      foreach (bucket_head[i]) bucket_head[i] = '0;
      node_fill   = 0;
      match_total = '0;
    endfunction

    function logic [BKT_W-1:0] bucket_index(logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] h;
      h = key * HASH_MULT;
      h = h ^ (h >> 16);
      return h[BKT_W-1:0];
    endfunction

    function logic [CNT_W-1:0] sat_count(int unsigned v);
      return (v > CNT_MAX) ? CNT_MAX : v[CNT_W-1:0];
    endfunction

    // Apply one accepted transaction to the model and queue its result
    function void note_item(logic [1:0] action, logic [KEY_W-1:0] key);
      join_result_t     res;
      logic [BKT_W-1:0] b;
      logic [PTR_W-1:0] p;
      int unsigned      hits;
      int unsigned      steps;
      longint unsigned  sum;
      res  = '0;
      hits = 0;
      case (action)
        ACT_INSERT: begin
          if (node_fill >= NODES) begin
            res.status = 1'b1;
          end else begin
            b = bucket_index(key);
            node_key[node_fill]  = key;
            node_link[node_fill] = bucket_head[b];
            node_fill++;
            bucket_head[b] = PTR_W'(node_fill);
          end
        end
        ACT_PROBE: begin
          // walk the chain, bounded by the fill level
          p     = bucket_head[bucket_index(key)];
          steps = 0;
          while (p != 0 && p <= node_fill && steps < node_fill) begin
            if (node_key[p - 1] == key) hits++;
            p = node_link[p - 1];
            steps++;
          end
          sum = longint'(match_total) + hits;
          match_total = (sum > 64'hFFFF_FFFF) ? '1 : sum[SUM_W-1:0];
        end
        ACT_CLEAR: empty_table();
        default: ;
      endcase
      res.match_count   = sat_count(hits);
      res.total_matches = match_total;
      res.stored_nodes  = sat_count(node_fill);
      pending_results.insert(pending_results.size(), res);
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Check one accepted result against the oldest expectation
    function void check_result(join_result_t got);
      join_result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual status=%0d count=%0d",
                 $time, got.status, got.match_count);
        $display("%0t:   actual total=%0d stored=%0d",
                 $time, got.total_matches, got.stored_nodes);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("match_count", want.match_count, got.match_count);
      compare_field("total_matches", want.total_matches, got.total_matches);
      compare_field("stored_nodes", want.stored_nodes, got.stored_nodes);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  bit   hold_req;
  logic [KEY_W-1:0] key_pool [KEY_POOL];

  join_scoreboard sb = new();

  hjb_in_if  in_if ();
  hjb_out_if out_if ();

  hash_join_build_probe_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold on request
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    out_if.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = STALL_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = steady || ($urandom_range(99) >= 20);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result({out_if.status, out_if.match_count,
                       out_if.total_matches, out_if.stored_nodes});
  end

  // One transaction on the item channel, with an optional random gap first
  task automatic send_item(input logic [1:0] action, input logic [KEY_W-1:0] key);
    if (!steady) begin
      while ($urandom_range(99) < 20) begin
        in_if.valid = 1'b0;
        @(negedge clk);
      end
    end
    in_if.valid  = 1'b1;
    in_if.action = action;
    in_if.key    = key;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_item(action, key);
    @(negedge clk);
  endtask

  // Sender stays quiet until every owed result has arrived
  task automatic wait_results();
    in_if.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pool_or_random(int unsigned pct);
    return ($urandom_range(99) < pct) ? key_pool[$urandom_range(KEY_POOL - 1)] : $urandom;
  endfunction

  // Next key above this one that lands in the same bucket
  function automatic logic [KEY_W-1:0] next_same_bucket(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] k;
    k = key + 1;
    while (sb.bucket_index(k) != sb.bucket_index(key)) k++;
    return k;
  endfunction

  // Mostly inserts and probes over a small key set, some clears and unused actions
  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3)       send_item(ACT_CLEAR, $urandom);
    else if (pick < 5)  send_item(ACT_UNUSED, $urandom);
    else if (pick < 50) send_item(ACT_INSERT, pool_or_random(60));
    else                send_item(ACT_PROBE, pool_or_random(70));
  endtask

  // Main sequence
  initial begin
    logic [KEY_W-1:0] ka, kb, kc, hot_key;
    in_if.valid  = 1'b0;
    in_if.action = ACT_INSERT;
    in_if.key    = '0;
    steady   = 1'b0;
    hold_req = 1'b0;
    rst_n    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // key set with a colliding pair and the key extremes
    ka = $urandom;
    kb = next_same_bucket(ka);
    kc = next_same_bucket(kb);
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = ka;
    key_pool[3] = kb;

    // directed: empty probe, key extremes, duplicates, shared bucket, clear
    send_item(ACT_PROBE, '0);
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, '1);
    send_item(ACT_INSERT, '1);
    send_item(ACT_PROBE, '1);
    send_item(ACT_PROBE, '0);
    send_item(ACT_PROBE, 32'h5A5A_5A5A);
    send_item(ACT_UNUSED, 32'hA5A5_A5A5);
    send_item(ACT_INSERT, ka);
    send_item(ACT_INSERT, kb);
    send_item(ACT_INSERT, ka);
    send_item(ACT_PROBE, ka);
    send_item(ACT_PROBE, kb);
    send_item(ACT_PROBE, kc);
    send_item(ACT_CLEAR, '0);
    send_item(ACT_PROBE, '1);
    send_item(ACT_INSERT, 32'd1);
    send_item(ACT_UNUSED, '1);
    send_item(ACT_PROBE, 32'd1);
    wait_results();

    // random mix; long result stall early, then a stretch with no gaps
    for (int i = 0; i < MIX_ITEMS; i++) begin
      if (i == 200) hold_req = 1'b1;
      steady = (i >= 350 && i < 500);
      send_random_item();
    end
    steady = 1'b0;
    wait_results();

    // fill the pool with one key, then overflow it and walk the full chain
    hot_key = $urandom;
    send_item(ACT_CLEAR, $urandom);
    repeat (NODES) send_item(ACT_INSERT, hot_key);
    repeat (4) send_item(ACT_INSERT, $urandom);
    send_item(ACT_PROBE, hot_key);
    send_item(ACT_PROBE, next_same_bucket(hot_key));
    repeat (3) send_item(ACT_PROBE, $urandom);
    send_item(ACT_UNUSED, hot_key);
    send_item(ACT_PROBE, hot_key);
    send_item(ACT_CLEAR, hot_key);
    wait_results();

    // closing random mix
    repeat (TAIL_ITEMS) send_random_item();
    wait_results();
    repeat (50) @(posedge clk);

    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
